// File: rtl/twqs_pkg.sv
// ============================================================================
// twqs_pkg
// Shared constants for the three-class weighted queue scheduler: class and
// status codes, register map and default sizes.
// ============================================================================
package twqs_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 64;
    localparam int DEFAULT_ID_WIDTH    = 16;

    localparam int NUM_CLASSES = 3;
    localparam int CNT_W       = 4;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    localparam logic [APB_ADDR_W-1:0] ADDR_BURST_LIMIT = 2'd0;
    localparam logic [CNT_W-1:0]      BURST_LIMIT_RESET = 4'd3;

    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_DEQUEUE = 1'b1;

    localparam logic [1:0] ZONE_GREEN  = 2'd0;
    localparam logic [1:0] ZONE_YELLOW = 2'd1;
    localparam logic [1:0] ZONE_RED    = 2'd2;
    localparam logic [1:0] ZONE_NONE   = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [1:0] STATUS_INVALID = 2'd3;

endpackage

// File: rtl/three_class_weighted_queue_scheduler.sv
// ============================================================================
// three_class_weighted_queue_scheduler
// Three FIFO queues (green, yellow, red) of QUEUE_DEPTH identifiers each.
// An enqueue word appends a nonzero identifier to one class; a dequeue word
// serves red, then yellow, then green, each limited to burst_limit words
// (zero acts as one) in a row while another class is still eligible. Every
// request word yields exactly one result word. The block takes one request
// per cycle while the result register is empty or being drained: the
// request lands in an input register, then the class decision, pointer and
// count updates and the queue memory read complete into the result
// register. A stalled result holds the input register, so s_ready drops
// until m_ready returns. Each queue is a single-port-per-side memory with a
// registered read. The queue memories are not cleared; only pointers,
// occupancy and burst counts reset, so no clearing pass follows reset.
// ============================================================================
module three_class_weighted_queue_scheduler #(
    parameter int QUEUE_DEPTH = twqs_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ID_WIDTH    = twqs_pkg::DEFAULT_ID_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [twqs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [twqs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [twqs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic [1:0]                       s_zone,
    input  logic [ID_WIDTH-1:0]              s_item_id,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ID_WIDTH-1:0]              m_served_id,
    output logic [1:0]                       m_served_zone,
    output logic [1:0]                       m_status
);

    import twqs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] burst_limit_reg;

    logic                in_valid_reg;
    logic                in_req_reg;
    logic [1:0]          in_zone_reg;
    logic [ID_WIDTH-1:0] in_id_reg;

    logic       out_valid_reg;
    logic [1:0] served_zone_reg;
    logic [1:0] status_reg;

    logic [PTR_W-1:0]    rd_ptr_reg  [NUM_CLASSES];
    logic [PTR_W-1:0]    wr_ptr_reg  [NUM_CLASSES];
    logic [OCC_W-1:0]    occ_reg     [NUM_CLASSES];
    logic [CNT_W-1:0]    cnt_reg     [NUM_CLASSES];
    logic [ID_WIDTH-1:0] rd_data_reg [NUM_CLASSES];

    logic [PTR_W-1:0] rd_ptr_next [NUM_CLASSES];
    logic [PTR_W-1:0] wr_ptr_next [NUM_CLASSES];
    logic [OCC_W-1:0] occ_next    [NUM_CLASSES];
    logic [CNT_W-1:0] cnt_next    [NUM_CLASSES];

    logic                   advance;
    logic                   in_take;
    logic                   cfg_write;
    logic                   is_enq;
    logic                   bad_req;
    logic                   enq_full;
    logic                   any_elig;
    logic [CNT_W-1:0]       limit;
    logic [NUM_CLASSES-1:0] nonempty;
    logic [NUM_CLASSES-1:0] elig;
    logic [NUM_CLASSES-1:0] cand;
    logic [NUM_CLASSES-1:0] full;
    logic [NUM_CLASSES-1:0] enq_hit;
    logic [NUM_CLASSES-1:0] push;
    logic [NUM_CLASSES-1:0] pop;
    logic [1:0]             pick;
    logic [1:0]             served_zone_next;
    logic [1:0]             status_next;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_BURST_LIMIT) begin
            prdata = {{(APB_DATA_W-CNT_W){1'b0}}, burst_limit_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_limit_reg <= BURST_LIMIT_RESET;
        end else if (cfg_write && paddr == ADDR_BURST_LIMIT) begin
            burst_limit_reg <= pwdata[CNT_W-1:0];
        end
    end

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_req_reg  <= s_req_type;
            in_zone_reg <= s_zone;
            in_id_reg   <= s_item_id;
        end
    end

    // class decision
    assign is_enq  = (in_req_reg == REQ_ENQUEUE);
    assign bad_req = (in_zone_reg == ZONE_NONE) || (in_id_reg == '0);
    assign limit   = (burst_limit_reg == '0) ? CNT_W'(1) : burst_limit_reg;

    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            nonempty[c] = (occ_reg[c] != '0);
            elig[c]     = nonempty[c] && (cnt_reg[c] < limit);
            full[c]     = (occ_reg[c] == OCC_W'(QUEUE_DEPTH));
            enq_hit[c]  = is_enq && (in_zone_reg == 2'(c));
        end
    end

    assign any_elig = |elig;
    assign cand     = any_elig ? elig : nonempty;
    assign enq_full = |(enq_hit & full);

    always_comb begin
        if (cand[ZONE_RED]) begin
            pick = ZONE_RED;
        end else if (cand[ZONE_YELLOW]) begin
            pick = ZONE_YELLOW;
        end else if (cand[ZONE_GREEN]) begin
            pick = ZONE_GREEN;
        end else begin
            pick = ZONE_NONE;
        end
    end

    always_comb begin
        if (is_enq) begin
            served_zone_next = ZONE_NONE;
            if (bad_req) begin
                status_next = STATUS_INVALID;
            end else if (enq_full) begin
                status_next = STATUS_FULL;
            end else begin
                status_next = STATUS_OK;
            end
        end else begin
            served_zone_next = pick;
            status_next      = (pick == ZONE_NONE) ? STATUS_EMPTY : STATUS_OK;
        end
    end

    // queue state update
    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            push[c] = advance && enq_hit[c] && !bad_req && !full[c];
            pop[c]  = advance && !is_enq && (pick == 2'(c));

            wr_ptr_next[c] = wr_ptr_reg[c];
            rd_ptr_next[c] = rd_ptr_reg[c];
            occ_next[c]    = occ_reg[c];
            if (push[c]) begin
                wr_ptr_next[c] = (wr_ptr_reg[c] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : wr_ptr_reg[c] + 1'b1;
                occ_next[c]    = occ_reg[c] + 1'b1;
            end
            if (pop[c]) begin
                rd_ptr_next[c] = (rd_ptr_reg[c] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                 '0 : rd_ptr_reg[c] + 1'b1;
                occ_next[c]    = occ_reg[c] - 1'b1;
            end

            cnt_next[c] = cnt_reg[c];
            if (advance && !is_enq) begin
                cnt_next[c] = any_elig ? cnt_reg[c] : '0;
                if (pick == 2'(c)) begin
                    cnt_next[c] = cnt_next[c] + 1'b1;
                end
            end
        end
        // clear higher classes when a lower one is served
        if (advance && !is_enq && (pick == ZONE_YELLOW || pick == ZONE_GREEN)) begin
            cnt_next[ZONE_RED] = '0;
        end
        if (advance && !is_enq && pick == ZONE_GREEN) begin
            cnt_next[ZONE_YELLOW] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                rd_ptr_reg[c] <= '0;
                wr_ptr_reg[c] <= '0;
                occ_reg[c]    <= '0;
                cnt_reg[c]    <= '0;
            end
        end else begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                rd_ptr_reg[c] <= rd_ptr_next[c];
                wr_ptr_reg[c] <= wr_ptr_next[c];
                occ_reg[c]    <= occ_next[c];
                cnt_reg[c]    <= cnt_next[c];
            end
        end
    end

    // queue memories
    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_queue
        logic [ID_WIDTH-1:0] mem [QUEUE_DEPTH];

        always_ff @(posedge aclk) begin
            if (push[g]) begin
                mem[wr_ptr_reg[g]] <= in_id_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (pop[g]) begin
                rd_data_reg[g] <= mem[rd_ptr_reg[g]];
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            served_zone_reg <= served_zone_next;
            status_reg      <= status_next;
        end
    end

    always_comb begin
        case (served_zone_reg)
            ZONE_GREEN:  m_served_id = rd_data_reg[ZONE_GREEN];
            ZONE_YELLOW: m_served_id = rd_data_reg[ZONE_YELLOW];
            ZONE_RED:    m_served_id = rd_data_reg[ZONE_RED];
            default:     m_served_id = '0;
        endcase
    end

    assign m_valid       = out_valid_reg;
    assign m_served_zone = served_zone_reg;
    assign m_status      = status_reg;

endmodule

// File: rtl/twqs_checker.sv
// ============================================================================
// twqs_port_checker
// Port-level checks for the three-class weighted queue scheduler, bound to
// the top level.
// ============================================================================
module twqs_port_checker #(
    parameter int ID_WIDTH = twqs_pkg::DEFAULT_ID_WIDTH
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                pready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [ID_WIDTH-1:0] m_served_id,
    input logic [1:0]          m_served_zone,
    input logic [1:0]          m_status
);

    import twqs_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_served_id)
            && $stable(m_served_zone) && $stable(m_status))
        else $error("result word changed while stalled");

    a_none_zero_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_served_zone == ZONE_NONE |-> m_served_id == '0)
        else $error("identifier reported with no class served");

    a_served_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_served_zone != ZONE_NONE |->
            m_status == STATUS_OK && m_served_id != '0)
        else $error("served word without ok status or with reserved id");

    a_empty_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_EMPTY || m_status == STATUS_FULL
            || m_status == STATUS_INVALID) |-> m_served_zone == ZONE_NONE)
        else $error("error status with a class served");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && pready)
        else $error("result valid right after reset");

endmodule

bind three_class_weighted_queue_scheduler twqs_port_checker #(.ID_WIDTH(ID_WIDTH))
    u_twqs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .pready        (pready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_served_id   (m_served_id),
    .m_served_zone (m_served_zone),
    .m_status      (m_status)
);

// File: tb/sv/twqs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twqs_checker
// Passive scoreboard for the three-class weighted queue scheduler. It
// snoops register writes and reads, models the three class queues, their
// pointers, occupancy and burst counts, predicts one result word per
// accepted request word, and compares each accepted result word field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module twqs_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [twqs_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [twqs_pkg::APB_DATA_W-1:0]       pwdata,
    input  logic [twqs_pkg::APB_DATA_W-1:0]       prdata,
    input  logic                                  pready,

    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic                                  s_req_type,
    input  logic [1:0]                            s_zone,
    input  logic [twqs_pkg::DEFAULT_ID_WIDTH-1:0] s_item_id,

    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [twqs_pkg::DEFAULT_ID_WIDTH-1:0] m_served_id,
    input  logic [1:0]                            m_served_zone,
    input  logic [1:0]                            m_status,

    output int                                    mismatches,
    output int                                    pending,
    output int                                    results_checked,
    output int                                    full_drops,
    output int                                    empty_polls
);

    import twqs_pkg::*;

    localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
    localparam int ID_W  = DEFAULT_ID_WIDTH;
    localparam int PTR_W = $clog2(DEPTH);

    typedef struct packed {
        logic [ID_W-1:0] served_id;
        logic [1:0]      served_zone;
        logic [1:0]      status;
    } sched_result_t;

    logic [ID_W-1:0]  class_store [NUM_CLASSES][DEPTH];
    logic [PTR_W-1:0] rd_ptr      [NUM_CLASSES];
    logic [PTR_W-1:0] wr_ptr      [NUM_CLASSES];
    logic [PTR_W:0]   occ         [NUM_CLASSES];
    logic [CNT_W-1:0] burst_cnt   [NUM_CLASSES];
    logic [CNT_W-1:0] burst_limit;

    sched_result_t    expected_results [$];

    initial begin
        mismatches      = 0;
        pending         = 0;
        results_checked = 0;
        full_drops      = 0;
        empty_polls     = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %0s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic logic [1:0] pick_class(input logic [CNT_W-1:0] lim);
        if (burst_cnt[ZONE_RED] < lim && occ[ZONE_RED] != 0)
            return ZONE_RED;
        if (burst_cnt[ZONE_YELLOW] < lim && occ[ZONE_YELLOW] != 0)
            return ZONE_YELLOW;
        if (burst_cnt[ZONE_GREEN] < lim && occ[ZONE_GREEN] != 0)
            return ZONE_GREEN;
        return ZONE_NONE;
    endfunction

    function automatic sched_result_t schedule_request(input logic rq, input logic [1:0] zn,
                                                       input logic [ID_W-1:0] id);
        sched_result_t    r;
        logic [1:0]       cls;
        logic [CNT_W-1:0] lim;
        r.served_id   = '0;
        r.served_zone = ZONE_NONE;
        r.status      = STATUS_OK;
        if (rq == REQ_ENQUEUE) begin
            if (zn == ZONE_NONE || id == '0) begin
                r.status = STATUS_INVALID;
            end else if (occ[zn] >= DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                class_store[zn][wr_ptr[zn]] = id;
                wr_ptr[zn] = wr_ptr[zn] + 1'b1;
                occ[zn]    = occ[zn] + 1'b1;
            end
        end else begin
            lim = (burst_limit == '0) ? CNT_W'(1) : burst_limit;
            cls = pick_class(lim);
            if (cls == ZONE_NONE) begin
                for (int c = 0; c < NUM_CLASSES; c++)
                    burst_cnt[c] = '0;
                cls = pick_class(lim);
            end
            if (cls == ZONE_NONE) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.served_id   = class_store[cls][rd_ptr[cls]];
                r.served_zone = cls;
                rd_ptr[cls]    = rd_ptr[cls] + 1'b1;
                occ[cls]       = occ[cls] - 1'b1;
                burst_cnt[cls] = burst_cnt[cls] + 1'b1;
                if (cls == ZONE_YELLOW) begin
                    burst_cnt[ZONE_RED] = '0;
                end else if (cls == ZONE_GREEN) begin
                    burst_cnt[ZONE_RED]    = '0;
                    burst_cnt[ZONE_YELLOW] = '0;
                end
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        sched_result_t want;
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                rd_ptr[c]    = '0;
                wr_ptr[c]    = '0;
                occ[c]       = '0;
                burst_cnt[c] = '0;
            end
            burst_limit = BURST_LIMIT_RESET;
            expected_results.delete();
        end else begin
            if (psel && penable && pready && paddr == ADDR_BURST_LIMIT) begin
                if (pwrite)
                    burst_limit = pwdata[CNT_W-1:0];
                else if (prdata !== {{(APB_DATA_W-CNT_W){1'b0}}, burst_limit})
                    report_mismatch("burst_limit readback", prdata, 32'(burst_limit));
            end
            if (s_valid && s_ready)
                expected_results.push_back(schedule_request(s_req_type, s_zone, s_item_id));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result word", 32'(m_served_id), 32'h0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_served_id !== want.served_id)
                        report_mismatch("served_id", 32'(m_served_id), 32'(want.served_id));
                    if (m_served_zone !== want.served_zone)
                        report_mismatch("served_zone", 32'(m_served_zone),
                                        32'(want.served_zone));
                    if (m_status !== want.status)
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                    if (want.status == STATUS_FULL)
                        full_drops++;
                    if (want.status == STATUS_EMPTY)
                        empty_polls++;
                    results_checked++;
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the three-class weighted queue scheduler. After a
// short directed pass over the special cases, random request words run in
// segments under several burst limits (including 0, 1 and 15) and three
// handshake idle mixes. Fill and drain sequences push queues to full and
// wrap their pointers. Checking lives in twqs_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import twqs_pkg::*;

    localparam int ID_W     = DEFAULT_ID_WIDTH;
    localparam int SEG_NUM  = 6;
    localparam int SEG_LEN  = 270;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic                  s_req_type = 1'b0;
    logic [1:0]            s_zone     = '0;
    logic [ID_W-1:0]       s_item_id  = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic [ID_W-1:0]       m_served_id;
    logic [1:0]            m_served_zone;
    logic [1:0]            m_status;

    int mismatches;
    int pending;
    int results_checked;
    int full_drops;
    int empty_polls;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int words_sent   = 0;
    int limits_set   = 0;

    three_class_weighted_queue_scheduler u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_zone        (s_zone),
        .s_item_id     (s_item_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_served_id   (m_served_id),
        .m_served_zone (m_served_zone),
        .m_status      (m_status)
    );

    twqs_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_zone          (s_zone),
        .s_item_id       (s_item_id),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_served_id     (m_served_id),
        .m_served_zone   (m_served_zone),
        .m_status        (m_status),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .full_drops      (full_drops),
        .empty_polls     (empty_polls)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_word(input logic rq, input logic [1:0] zn, input logic [ID_W-1:0] id);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= rq;
        s_zone     <= zn;
        s_item_id  <= id;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_BURST_LIMIT;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [ID_W-1:0] random_id();
        return ID_W'($urandom_range(1, (1 << ID_W) - 1));
    endfunction

    task automatic run_segment(input int n_words);
        int         start_count;
        int         pick;
        int         n;
        logic [1:0] cls;
        start_count = words_sent;
        while (words_sent - start_count < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                n = $urandom_range(8, 24);
                repeat (n) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50)
                        send_word(REQ_ENQUEUE, 2'($urandom_range(0, 2)), random_id());
                    else if (pick < 52)
                        send_word(REQ_ENQUEUE, ZONE_NONE, ID_W'($urandom));
                    else if (pick < 54)
                        send_word(REQ_ENQUEUE, 2'($urandom_range(0, 2)), '0);
                    else
                        send_word(REQ_DEQUEUE, 2'($urandom), ID_W'($urandom));
                end
            end else if (pick < 55) begin
                cls = 2'($urandom_range(0, 2));
                n = $urandom_range(66, 72);
                repeat (n) send_word(REQ_ENQUEUE, cls, random_id());
                repeat (n + 4) send_word(REQ_DEQUEUE, 2'($urandom), ID_W'($urandom));
            end else if (pick < 72) begin
                cls = 2'($urandom_range(0, 2));
                repeat ($urandom_range(4, 20)) send_word(REQ_ENQUEUE, cls, random_id());
            end else if (pick < 92) begin
                repeat ($urandom_range(4, 40))
                    send_word(REQ_DEQUEUE, 2'($urandom), ID_W'($urandom));
            end else if (pick < 96) begin
                repeat ($urandom_range(2, 6)) begin
                    if ($urandom_range(0, 1))
                        send_word(REQ_ENQUEUE, ZONE_NONE, ID_W'($urandom));
                    else
                        send_word(REQ_ENQUEUE, 2'($urandom), '0);
                end
            end else begin
                wait_drained();
            end
        end
    endtask

    initial begin
        logic [CNT_W-1:0] seg_limit [SEG_NUM];
        seg_limit[0] = CNT_W'(1);
        seg_limit[1] = CNT_W'(15);
        seg_limit[2] = CNT_W'(0);
        seg_limit[3] = CNT_W'($urandom_range(3, 14));
        seg_limit[4] = CNT_W'(2);
        seg_limit[5] = CNT_W'($urandom_range(1, 15));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_cycle(1'b0, '0);

        send_word(REQ_DEQUEUE, ZONE_NONE, '0);
        send_word(REQ_ENQUEUE, ZONE_NONE, ID_W'(16'h0005));
        send_word(REQ_ENQUEUE, ZONE_GREEN, '0);
        send_word(REQ_ENQUEUE, ZONE_NONE, '0);
        send_word(REQ_ENQUEUE, ZONE_GREEN, ID_W'(16'hFFFF));
        send_word(REQ_ENQUEUE, ZONE_YELLOW, ID_W'(16'h0001));
        send_word(REQ_ENQUEUE, ZONE_RED, ID_W'(16'h8000));
        send_word(REQ_ENQUEUE, ZONE_RED, ID_W'(16'h7FFF));
        send_word(REQ_ENQUEUE, ZONE_RED, ID_W'(16'hAAAA));
        send_word(REQ_ENQUEUE, ZONE_RED, ID_W'(16'h5555));
        send_word(REQ_ENQUEUE, ZONE_YELLOW, ID_W'(16'hFFFE));
        send_word(REQ_ENQUEUE, ZONE_GREEN, ID_W'(16'h0002));
        send_word(REQ_DEQUEUE, ZONE_RED, ID_W'(16'hFFFF));
        repeat (8) send_word(REQ_DEQUEUE, ZONE_GREEN, '0);
        send_word(REQ_DEQUEUE, ZONE_YELLOW, ID_W'(16'h1234));
        wait_drained();

        for (int seg = 0; seg < SEG_NUM; seg++) begin
            case (seg / 2)
                0: begin
                    src_idle_pct = 31;
                    snk_idle_pct = 79;
                end
                1: begin
                    src_idle_pct = 79;
                    snk_idle_pct = 31;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            wait_drained();
            apb_cycle(1'b1, APB_DATA_W'(seg_limit[seg]));
            apb_cycle(1'b0, '0);
            limits_set++;
            run_segment(SEG_LEN);
        end

        wait_drained();
        repeat (10) @(posedge aclk);

        $display("Covered %0d request words over %0d burst-limit settings and three idle mixes.",
                 words_sent, limits_set);
        $display("Checked %0d result words, %0d full-queue drops, %0d empty dequeues.",
                 results_checked, full_drops, empty_polls);
        if (mismatches == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
